>>> rtl/core/stv_pkg.sv
`timescale 1ns / 1ps

package stv_pkg;

	// Pipeline depths of the sub-units
	localparam int POLY_LAT = 4;
	localparam int SQ_STEPS = 30;
	localparam int LOG_LAT  = SQ_STEPS + 3;
	localparam int QBITS    = 25;
	localparam int DIV_LAT  = QBITS;
	localparam int SIDE_LAT = LOG_LAT + DIV_LAT - POLY_LAT;

	// ln(2) in Q.30 and Q.32
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	// Register indexes
	localparam logic [2:0] REG_COEF_A1  = 3'd0;
	localparam logic [2:0] REG_COEF_A2  = 3'd1;
	localparam logic [2:0] REG_COEF_A3  = 3'd2;
	localparam logic [2:0] REG_COEF_B1  = 3'd3;
	localparam logic [2:0] REG_COEF_B2  = 3'd4;
	localparam logic [2:0] REG_COEF_B3  = 3'd5;
	localparam logic [2:0] REG_TIME_K   = 3'd6;
	localparam logic [2:0] REG_PLASMA   = 3'd7;

	typedef struct packed {
		logic signed [31:0] a1;
		logic signed [31:0] a2;
		logic signed [31:0] a3;
		logic signed [31:0] b1;
		logic signed [31:0] b2;
		logic signed [31:0] b3;
	} stv_coef_t;

	// Polynomial results with the hematocrit that produced them
	typedef struct packed {
		logic [15:0]        h;
		logic signed [35:0] pa;
		logic signed [35:0] pb;
	} stv_side_t;

	// Log unit result: u and the dividend 1 + ln(u) in Q.30
	typedef struct packed {
		logic [63:0] u;
		logic [35:0] num;
	} stv_logres_t;

endpackage

>>> rtl/core/shear_thinning_blood_viscosity_top.sv
`timescale 1ns / 1ps
// Throughput: one transaction per cycle; the pipeline holds as a whole while
// the output register is full and not taken.
// The 30 squaring steps of the log and 25 quotient bits of the divide set the depth.
// Reset: arst_n asynchronous, clears valid bits and configuration registers to zero.

module shear_thinning_blood_viscosity_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // hematocrit [15:0], shear_rate [47:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // viscosity [31:0]
	output logic [0:0]  m_tuser,   // saturated [0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int SD = stv_pkg::SIDE_LAT;

	logic [31:0] coef_a1_q, coef_a2_q, coef_a3_q;
	logic [31:0] coef_b1_q, coef_b2_q, coef_b3_q;
	logic [31:0] time_k_q, plasma_q;
	stv_pkg::stv_coef_t coef;

	logic        en;
	logic        v_s1;
	logic [15:0] h_s1;
	logic [63:0] kg_s1;
	logic [63:0] u_in;

	logic                 poly_vld;
	stv_pkg::stv_side_t   poly_side;
	stv_pkg::stv_side_t   side_s [SD];
	logic                 log_vld;
	stv_pkg::stv_logres_t log_res;
	logic                 div_vld;
	logic [24:0]          f_q;

	logic               v_s60, v_s61, v_s62;
	logic signed [62:0] prod_s60;
	logic signed [35:0] pb_s60;
	logic [15:0]        h_s60, h_s61;
	logic signed [38:0] inner_s61;
	logic signed [55:0] t1_s62;
	logic signed [49:0] t2_s62;
	logic signed [36:0] diff;
	logic [16:0]        hc;
	logic signed [56:0] sum;
	logic signed [38:0] mu;
	logic               sat;
	logic               ovld_q;
	logic [31:0]        vis_q;
	logic               sat_q;
	logic               wr;

	// Configuration write and read
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a1_q <= 32'd0;
			coef_a2_q <= 32'd0;
			coef_a3_q <= 32'd0;
			coef_b1_q <= 32'd0;
			coef_b2_q <= 32'd0;
			coef_b3_q <= 32'd0;
			time_k_q  <= 32'd0;
			plasma_q  <= 32'd0;
		end else if (wr) begin
			unique case (paddr[4:2])
				stv_pkg::REG_COEF_A1: coef_a1_q <= pwdata;
				stv_pkg::REG_COEF_A2: coef_a2_q <= pwdata;
				stv_pkg::REG_COEF_A3: coef_a3_q <= pwdata;
				stv_pkg::REG_COEF_B1: coef_b1_q <= pwdata;
				stv_pkg::REG_COEF_B2: coef_b2_q <= pwdata;
				stv_pkg::REG_COEF_B3: coef_b3_q <= pwdata;
				stv_pkg::REG_TIME_K:  time_k_q  <= pwdata;
				stv_pkg::REG_PLASMA:  plasma_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			stv_pkg::REG_COEF_A1: prdata = coef_a1_q;
			stv_pkg::REG_COEF_A2: prdata = coef_a2_q;
			stv_pkg::REG_COEF_A3: prdata = coef_a3_q;
			stv_pkg::REG_COEF_B1: prdata = coef_b1_q;
			stv_pkg::REG_COEF_B2: prdata = coef_b2_q;
			stv_pkg::REG_COEF_B3: prdata = coef_b3_q;
			stv_pkg::REG_TIME_K:  prdata = time_k_q;
			stv_pkg::REG_PLASMA:  prdata = plasma_q;
			default:              prdata = 32'd0;
		endcase
	end

	assign coef.a1 = coef_a1_q;
	assign coef.a2 = coef_a2_q;
	assign coef.a3 = coef_a3_q;
	assign coef.b1 = coef_b1_q;
	assign coef.b2 = coef_b2_q;
	assign coef.b3 = coef_b3_q;

	// Advance the whole pipeline while the output register can take a result
	assign en       = !ovld_q || m_tready;
	assign s_tready = en;

	// Input stage: k times shear rate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s1  <= s_tdata[15:0];
			kg_s1 <= {32'd0, time_k_q} * {32'd0, s_tdata[47:16]};
		end
	end

	assign u_in = kg_s1 + (64'd1 << 32);

	stv_poly u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.h         (h_s1),
		.coef      (coef),
		.out_valid (poly_vld),
		.side      (poly_side)
	);

	stv_log u_log (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.u         (u_in),
		.out_valid (log_vld),
		.res       (log_res)
	);

	stv_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (log_vld),
		.din       (log_res),
		.out_valid (div_vld),
		.quo       (f_q)
	);

	// Delay polynomial results to meet the shear factor
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= poly_side;
			for (int i = 1; i < SD; i++) side_s[i] <= side_s[i-1];
		end
	end

	// Blend stages
	assign diff = 37'(side_s[SD-1].pa) - 37'(side_s[SD-1].pb);
	assign hc   = 17'(18'd65536 - {2'd0, h_s61});
	assign sum  = 57'(t1_s62) + 57'($signed({t2_s62, 2'b00}));
	assign mu   = sum[56:18];
	assign sat  = (mu > 39'sd2147483647) || (mu < -39'sd2147483648);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s60  <= 1'b0;
			v_s61  <= 1'b0;
			v_s62  <= 1'b0;
			ovld_q <= 1'b0;
		end else if (en) begin
			v_s60  <= div_vld;
			v_s61  <= v_s60;
			v_s62  <= v_s61;
			ovld_q <= v_s62;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s60  <= diff * $signed({1'b0, f_q});
			pb_s60    <= side_s[SD-1].pb;
			h_s60     <= side_s[SD-1].h;
			inner_s61 <= 39'(pb_s60) + 39'(prod_s60 >>> 24);
			h_s61     <= h_s60;
			t1_s62    <= inner_s61 * $signed({1'b0, h_s61});
			t2_s62    <= $signed(plasma_q) * $signed({1'b0, hc});
			sat_q     <= sat;
			if (mu > 39'sd2147483647) begin
				vis_q <= 32'h7FFF_FFFF;
			end else if (mu < -39'sd2147483648) begin
				vis_q <= 32'h8000_0000;
			end else begin
				vis_q <= mu[31:0];
			end
		end
	end

	assign m_tvalid   = ovld_q;
	assign m_tdata    = vis_q;
	assign m_tuser[0] = sat_q;

`ifndef SYNTH
	// Clipped results sit at a rail
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata == 32'h7FFF_FFFF || m_tdata == 32'h8000_0000))
		else $error("saturated result off the rail");

	// The shear factor never exceeds one
	a_f_max: assert property (@(posedge clk) disable iff (!arst_n)
		div_vld |-> f_q <= 25'h100_0000)
		else $error("shear factor above one");

	// The log dividend is at least one
	a_num_min: assert property (@(posedge clk) disable iff (!arst_n)
		log_vld |-> log_res.num >= (36'd1 << 30))
		else $error("log dividend below one");

	// A held result does not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ovld_q && !m_tready |=> $stable(vis_q) && $stable(sat_q))
		else $error("held result changed");
`endif

endmodule

>>> rtl/core/stv_poly.sv
`timescale 1ns / 1ps

module stv_poly (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [15:0]            h,
	input  stv_pkg::stv_coef_t     coef,
	output logic                   out_valid,
	output stv_pkg::stv_side_t     side
);

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [15:0] h_s1, h_s2, h_s3, h_s4;
	logic [15:0] h2_s1, h2_s2;
	logic [15:0] h3_s2;
	logic signed [48:0] pa1_s3, pa2_s3, pa3_s3;
	logic signed [48:0] pb1_s3, pb2_s3, pb3_s3;
	logic signed [35:0] pa_s4, pb_s4;
	logic [31:0] sq_h;
	logic [31:0] cube_h;
	logic signed [50:0] sum_a, sum_b;

	// Square and cube of H, floored to Q0.16
	assign sq_h   = {16'd0, h} * {16'd0, h};
	assign cube_h = {16'd0, h2_s1} * {16'd0, h_s1};

	// Polynomial sums in Q.44
	assign sum_a = 51'(pa1_s3) + 51'(pa2_s3) + 51'(pa3_s3);
	assign sum_b = 51'(pb1_s3) + 51'(pb2_s3) + 51'(pb3_s3);

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			h_s1   <= h;
			h2_s1  <= sq_h[31:16];
			h_s2   <= h_s1;
			h2_s2  <= h2_s1;
			h3_s2  <= cube_h[31:16];
			h_s3   <= h_s2;
			pa1_s3 <= coef.a1 * $signed({1'b0, h_s2});
			pa2_s3 <= coef.a2 * $signed({1'b0, h2_s2});
			pa3_s3 <= coef.a3 * $signed({1'b0, h3_s2});
			pb1_s3 <= coef.b1 * $signed({1'b0, h_s2});
			pb2_s3 <= coef.b2 * $signed({1'b0, h2_s2});
			pb3_s3 <= coef.b3 * $signed({1'b0, h3_s2});
			h_s4   <= h_s3;
			pa_s4  <= sum_a[49:14];
			pb_s4  <= sum_b[49:14];
		end
	end

	assign out_valid = v_s4;
	assign side.h    = h_s4;
	assign side.pa   = pa_s4;
	assign side.pb   = pb_s4;

endmodule

>>> rtl/core/stv_log.sv
`timescale 1ns / 1ps

module stv_log (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [63:0]            u,
	output logic                   out_valid,
	output stv_pkg::stv_logres_t   res
);

	localparam int N = stv_pkg::SQ_STEPS;
	localparam logic [29:0] LN2_Q30_EXT = stv_pkg::LN2_Q30;

	logic        v_s1, v_s2;
	logic [63:0] u_s1;
	logic [4:0]  e_s1;
	logic        sq_v_s  [1:N];
	logic [30:0] sq_m_s  [N+1];
	logic [29:0] sq_f_s  [N+1];
	logic [4:0]  sq_e_s  [N+1];
	logic [63:0] sq_u_s  [N+1];
	logic [61:0] sq_p    [N];
	logic [5:0]  shamt;
	logic [63:0] u_shift;
	logic        v_out_s;
	logic [63:0] u_out_s;
	logic [35:0] num_out_s;
	logic [34:0] ln_int;
	logic [61:0] ln_frac;
	logic [35:0] num_next;

	// Position of the leading one in the upper word
	function automatic logic [4:0] lead_one(input logic [31:0] w);
		logic [4:0] p;
		p = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (w[i]) p = 5'(i);
		end
		return p;
	endfunction

	// Normalize to a Q1.30 mantissa
	assign shamt   = {1'b0, e_s1} + 6'd2;
	assign u_shift = u_s1 >> shamt;

	// Square each mantissa
	always_comb begin
		for (int i = 0; i < N; i++) begin
			sq_p[i] = {31'd0, sq_m_s[i]} * {31'd0, sq_m_s[i]};
		end
	end

	// Combine integer and fraction parts of log2 into ln
	assign ln_int   = {30'd0, sq_e_s[N]} * {5'd0, LN2_Q30_EXT};
	assign ln_frac  = {32'd0, sq_f_s[N]} * {30'd0, stv_pkg::LN2_Q32};
	assign num_next = 36'd1 << 30;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_out_s <= 1'b0;
			for (int i = 1; i <= N; i++) sq_v_s[i] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			sq_v_s[1] <= v_s2;
			for (int i = 2; i <= N; i++) sq_v_s[i] <= sq_v_s[i-1];
			v_out_s <= sq_v_s[N];
		end
	end

	// Advance payload through the squaring steps
	always_ff @(posedge clk) begin
		if (en) begin
			u_s1 <= u;
			e_s1 <= lead_one(u[63:32]);
			sq_u_s[0] <= u_s1;
			sq_e_s[0] <= e_s1;
			sq_m_s[0] <= u_shift[30:0];
			sq_f_s[0] <= 30'd0;
			for (int i = 1; i <= N; i++) begin
				sq_u_s[i] <= sq_u_s[i-1];
				sq_e_s[i] <= sq_e_s[i-1];
				if (sq_p[i-1][61]) begin
					sq_m_s[i] <= sq_p[i-1][61:31];
					sq_f_s[i] <= {sq_f_s[i-1][28:0], 1'b1};
				end else begin
					sq_m_s[i] <= sq_p[i-1][60:30];
					sq_f_s[i] <= {sq_f_s[i-1][28:0], 1'b0};
				end
			end
			u_out_s   <= sq_u_s[N];
			num_out_s <= num_next + {1'b0, ln_int} + {6'd0, ln_frac[61:32]};
		end
	end

	assign out_valid = v_out_s;
	assign res.u     = u_out_s;
	assign res.num   = num_out_s;

endmodule

>>> rtl/core/stv_div.sv
`timescale 1ns / 1ps

module stv_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  stv_pkg::stv_logres_t   din,
	output logic                   out_valid,
	output logic [24:0]            quo
);

	localparam int N = stv_pkg::DIV_LAT;

	logic        dv_s  [N];
	logic [63:0] rem_s [N];
	logic [63:0] den_s [N];
	logic [24:0] q_s   [N];
	logic [63:0] rem_p [N];
	logic [63:0] den_p [N];
	logic [24:0] q_p   [N];
	logic [64:0] trial [N];

	// Previous stage view; the dividend's low bits are all zero
	always_comb begin
		rem_p[0] = {27'd0, din.num, 1'b0};
		den_p[0] = din.u;
		q_p[0]   = 25'd0;
		for (int i = 1; i < N; i++) begin
			rem_p[i] = rem_s[i-1];
			den_p[i] = den_s[i-1];
			q_p[i]   = q_s[i-1];
		end
		for (int i = 0; i < N; i++) begin
			trial[i] = {rem_p[i], 1'b0};
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) dv_s[i] <= 1'b0;
		end else if (en) begin
			dv_s[0] <= in_valid;
			for (int i = 1; i < N; i++) dv_s[i] <= dv_s[i-1];
		end
	end

	// One restoring quotient bit per stage
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) begin
				den_s[i] <= den_p[i];
				if (trial[i] >= {1'b0, den_p[i]}) begin
					rem_s[i] <= 64'(trial[i] - {1'b0, den_p[i]});
					q_s[i]   <= {q_p[i][23:0], 1'b1};
				end else begin
					rem_s[i] <= trial[i][63:0];
					q_s[i]   <= {q_p[i][23:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = dv_s[N-1];
	assign quo       = q_s[N-1];

endmodule
